// ----- src/target_heading_average_and_rotate_macros.svh -----
// Assertion macros for the target heading averager and rotate block.
// Used by the port checker; they expect signals named clk and rst_n in scope.
`ifndef TARGET_HEADING_AVERAGE_AND_ROTATE_MACROS_SVH
`define TARGET_HEADING_AVERAGE_AND_ROTATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THAR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define THAR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/thar_pkg.sv -----
// Shared types and constants for the target heading averager and rotate block.
// No dependencies; the regs, controller, datapath, top and checker files use it by scoped names.
`timescale 1ns / 1ps

package thar_pkg;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  // Field widths.
  localparam int unsigned HEAD_W  = 20;
  localparam int unsigned ELEV_W  = 12;
  localparam int unsigned BEAR_W  = 12;
  localparam int unsigned ROT_W   = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DRIVE_W = 15;
  localparam int unsigned DBAND_W = 14;
  localparam int unsigned THR_W   = 4;

  // Heading error working width, wrapped magnitude width and product width.
  localparam int unsigned ERR_W  = 22;
  localparam int unsigned MAG_W  = 14;
  localparam int unsigned PROD_W = 30;

  // The wrap reduction subtracts or adds 23040 << j for j = 5 down to 0.
  localparam int unsigned WRAP_STEPS = 6;
  localparam int unsigned STEP_W     = 3;

  localparam logic signed [ERR_W-1:0] HALF_TURN     = 22'sd11520;
  localparam logic signed [ERR_W-1:0] NEG_HALF_TURN = -22'sd11520;
  localparam logic signed [ERR_W-1:0] FULL_TURN     = 22'sd23040;

  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 20'sh7FFFF;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = 20'sh80000;

  // Rotation scaling: (gain * |e| + 64) >> 7.
  localparam int unsigned ROUND_BIAS = 64;
  localparam int unsigned ROT_SHIFT  = 7;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_DRIVE = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DRIVE = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEADBAND  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOCK_THR  = 3'd4;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd393;
  localparam logic [DRIVE_W-1:0] MIN_DRIVE_RST = 15'd983;
  localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST = 15'd9830;
  localparam logic [DBAND_W-1:0] DEADBAND_RST  = 14'd32;
  localparam logic [THR_W-1:0]   LOCK_THR_RST  = 4'd4;

  // Divider operand select.
  localparam logic DIV_SEL_HEAD = 1'b0;
  localparam logic DIV_SEL_ELEV = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [DRIVE_W-1:0] min_drive;
    logic [DRIVE_W-1:0] max_drive;
    logic [DBAND_W-1:0] deadband;
    logic [THR_W-1:0]   lock_threshold;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic ring_wr;
    logic sweep;
    logic lock_upd;
    logic div_start;
    logic div_sel;
    logic held_h_ld;
    logic held_e_ld;
    logic wrap_init;
    logic wrap_step;
    logic mul_go;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic lock_ok;
    logic div_busy;
    logic wrap_last;
  } sts_t;

endpackage

// ----- src/thar_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module thar_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/thar_regs.sv -----
// Configuration register file behind an APB-style port.
// Depends on thar_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module thar_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [thar_pkg::ADDR_W-1:0]   paddr,
  input  logic [thar_pkg::DATA_W-1:0]   pwdata,
  output logic [thar_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output thar_pkg::cfg_t                cfg
);

  localparam int unsigned DW = thar_pkg::DATA_W;

  thar_pkg::cfg_t cfg_r, cfg_nxt;
  logic [thar_pkg::IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[thar_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register update on the access phase of a write transaction.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        thar_pkg::REG_GAIN:      cfg_nxt.gain = pwdata[thar_pkg::GAIN_W-1:0];
        thar_pkg::REG_MIN_DRIVE: cfg_nxt.min_drive = pwdata[thar_pkg::DRIVE_W-1:0];
        thar_pkg::REG_MAX_DRIVE: cfg_nxt.max_drive = pwdata[thar_pkg::DRIVE_W-1:0];
        thar_pkg::REG_DEADBAND:  cfg_nxt.deadband = pwdata[thar_pkg::DBAND_W-1:0];
        thar_pkg::REG_LOCK_THR:  cfg_nxt.lock_threshold = pwdata[thar_pkg::THR_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{gain:           thar_pkg::GAIN_RST,
                 min_drive:      thar_pkg::MIN_DRIVE_RST,
                 max_drive:      thar_pkg::MAX_DRIVE_RST,
                 deadband:       thar_pkg::DEADBAND_RST,
                 lock_threshold: thar_pkg::LOCK_THR_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux; unused addresses read as zero.
  always_comb begin
    unique case (idx)
      thar_pkg::REG_GAIN:      prdata = DW'(cfg_r.gain);
      thar_pkg::REG_MIN_DRIVE: prdata = DW'(cfg_r.min_drive);
      thar_pkg::REG_MAX_DRIVE: prdata = DW'(cfg_r.max_drive);
      thar_pkg::REG_DEADBAND:  prdata = DW'(cfg_r.deadband);
      thar_pkg::REG_LOCK_THR:  prdata = DW'(cfg_r.lock_threshold);
      default:                 prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- src/thar_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module thar_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(1))) begin
      busy_r <= 1'b0;
    end
  end

  // Datapath registers of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ----- src/thar_ctrl.sv -----
// Controller state machine that sequences one control tick through the datapath.
// Depends on thar_pkg for the command and status structs.
`timescale 1ns / 1ps

module thar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  thar_pkg::sts_t    sts,
  output thar_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_SWEEP = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_LOCK  = 4'd4;
  localparam logic [3:0] S_DIVH  = 4'd5;
  localparam logic [3:0] S_WAITH = 4'd6;
  localparam logic [3:0] S_DIVE  = 4'd7;
  localparam logic [3:0] S_WAITE = 4'd8;
  localparam logic [3:0] S_WRAP0 = 4'd9;
  localparam logic [3:0] S_WRAP  = 4'd10;
  localparam logic [3:0] S_MUL   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state, commands and output valid.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ring_wr = 1'b1;
        state_nxt   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOCK;
      end
      S_LOCK: begin
        cmd.lock_upd = 1'b1;
        state_nxt    = sts.lock_ok ? S_DIVH : S_WRAP0;
      end
      S_DIVH: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = thar_pkg::DIV_SEL_HEAD;
        state_nxt     = S_WAITH;
      end
      S_WAITH: begin
        if (!sts.div_busy) begin
          cmd.held_h_ld = 1'b1;
          state_nxt     = S_DIVE;
        end
      end
      S_DIVE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = thar_pkg::DIV_SEL_ELEV;
        state_nxt     = S_WAITE;
      end
      S_WAITE: begin
        if (!sts.div_busy) begin
          cmd.held_e_ld = 1'b1;
          state_nxt     = S_WRAP0;
        end
      end
      S_WRAP0: begin
        cmd.wrap_init = 1'b1;
        state_nxt     = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap_step = 1'b1;
        if (sts.wrap_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // Load the output register once it is empty or being emptied.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/thar_dp.sv -----
// Datapath: heading ring, averaging sweep, shared divider, error wrap and rotation.
// Depends on thar_pkg, thar_ram and thar_div.
`timescale 1ns / 1ps

module thar_dp #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  thar_pkg::cmd_t                      cmd,
  output thar_pkg::sts_t                      sts,
  input  thar_pkg::cfg_t                      cfg,
  input  logic signed [thar_pkg::BEAR_W-1:0]  in_bearing,
  input  logic signed [thar_pkg::ELEV_W-1:0]  in_elevation,
  input  logic                                in_seen,
  input  logic signed [thar_pkg::HEAD_W-1:0]  in_gyro_heading,
  input  logic                                in_gyro_ok,
  output logic                                out_locked,
  output logic signed [thar_pkg::HEAD_W-1:0]  out_mean_heading,
  output logic signed [thar_pkg::ELEV_W-1:0]  out_mean_elevation,
  output logic signed [thar_pkg::ROT_W-1:0]   out_rotation,
  output logic                                out_aligned
);

  localparam int unsigned HW   = thar_pkg::HEAD_W;
  localparam int unsigned EWD  = thar_pkg::ELEV_W;
  localparam int unsigned BW   = thar_pkg::BEAR_W;
  localparam int unsigned RTW  = thar_pkg::ROT_W;
  localparam int unsigned ERW  = thar_pkg::ERR_W;
  localparam int unsigned MGW  = thar_pkg::MAG_W;
  localparam int unsigned PW   = thar_pkg::PROD_W;
  localparam int unsigned DRW  = thar_pkg::DRIVE_W;
  localparam int unsigned TW   = thar_pkg::THR_W;
  localparam int unsigned SW   = thar_pkg::STEP_W;
  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SHW  = HW + AW;
  localparam int unsigned SEW  = EWD + AW;
  localparam int unsigned MW   = (CW > TW) ? CW : TW;
  localparam int unsigned RW   = HW + EWD;
  localparam int unsigned THW  = HW + 1;
  localparam int unsigned RNW  = PW - thar_pkg::ROT_SHIFT;
  localparam int unsigned MSW  = RNW + 1;

  // Input transaction latches.
  logic signed [BW-1:0]  bearing_r;
  logic signed [EWD-1:0] elev_r;
  logic                  seen_r;
  logic signed [HW-1:0]  gyro_r;
  logic                  gyro_ok_r;

  // Ring control and sweep.
  logic [AW-1:0]            slot_r;
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [AW-1:0]            rd_ptr_r;
  logic                     acc_en_r;
  logic [AW-1:0]            acc_idx_r;
  logic [RW-1:0]            ring_q;
  logic signed [HW-1:0]     ring_h;
  logic signed [EWD-1:0]    ring_e;
  logic signed [SHW-1:0]    sum_h_r;
  logic signed [SEW-1:0]    sum_e_r;
  logic [CW-1:0]            cnt_r;

  // Target heading of the new entry.
  logic signed [THW-1:0] th_wide;
  logic signed [HW-1:0]  th;

  // Lock and averages.
  logic [TW-1:0]         need;
  logic                  lock_r;
  logic signed [HW-1:0]  held_h_r;
  logic signed [EWD-1:0] held_e_r;
  logic [SHW-1:0]        mag_h;
  logic [SEW-1:0]        mag_e;
  logic [SHW-1:0]        div_num;
  logic [SHW-1:0]        div_quo;
  logic                  div_busy;
  logic [SHW-1:0]        quo_h;
  logic [SHW-1:0]        quo_e;

  // Wrap, multiply and rotation.
  logic signed [ERW-1:0] e_init;
  logic signed [ERW-1:0] e_r;
  logic                  wneg_r;
  logic [SW-1:0]         wj_r;
  logic signed [ERW-1:0] stepv;
  logic signed [ERW-1:0] cand_dn;
  logic signed [ERW-1:0] cand_up;
  logic [ERW-1:0]        abs_e;
  logic [MGW-1:0]        ae;
  logic [PW-1:0]         prod_r;
  logic [PW-1:0]         rnd;
  logic [MSW-1:0]        mag_sum;
  logic [DRW-1:0]        mag;
  logic [RTW-1:0]        mag_ext;
  logic signed [RTW-1:0] rot_val;
  logic                  active;
  logic                  band_hit;

  // Latch the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      bearing_r <= in_bearing;
      elev_r    <= in_elevation;
      seen_r    <= in_seen;
      gyro_r    <= in_gyro_heading;
      gyro_ok_r <= in_gyro_ok;
    end
  end

  // Gyro heading minus bearing, saturated to the heading range.
  assign th_wide = THW'(gyro_r) - THW'(bearing_r);
  always_comb begin
    if (th_wide[HW] != th_wide[HW-1]) begin
      th = th_wide[HW] ? thar_pkg::HEAD_MIN : thar_pkg::HEAD_MAX;
    end else begin
      th = th_wide[HW-1:0];
    end
  end

  // History ring; one entry written per tick, read once per entry in the sweep.
  thar_ram #(
    .WIDTH(RW),
    .DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring_wr),
    .waddr (slot_r),
    .wdata ({th, elev_r}),
    .re    (cmd.sweep),
    .raddr (rd_ptr_r),
    .rdata (ring_q)
  );

  assign ring_h = ring_q[RW-1:EWD];
  assign ring_e = ring_q[EWD-1:0];

  // Write slot and entry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= '0;
    end else if (cmd.ring_wr) begin
      valid_r[slot_r] <= seen_r && gyro_ok_r;
      slot_r          <= (slot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + AW'(1);
    end
  end

  // Sweep pointer and the accumulate enable, registered from the sweep command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      rd_ptr_r <= '0;
    end else if (cmd.sweep && (rd_ptr_r != AW'(HISTORY_DEPTH - 1))) begin
      rd_ptr_r <= rd_ptr_r + AW'(1);
    end
    acc_idx_r <= rd_ptr_r;
  end

  // Sum the valid entries as they come out of the ring.
  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      sum_h_r <= '0;
      sum_e_r <= '0;
      cnt_r   <= '0;
    end else if (acc_en_r && valid_r[acc_idx_r]) begin
      sum_h_r <= sum_h_r + SHW'(ring_h);
      sum_e_r <= sum_e_r + SEW'(ring_e);
      cnt_r   <= cnt_r + CW'(1);
    end
  end

  // Lock decision; a threshold of zero acts as one.
  assign need = (cfg.lock_threshold == '0) ? TW'(1) : cfg.lock_threshold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
    end else if (cmd.lock_upd) begin
      lock_r <= sts.lock_ok;
    end
  end

  // Rounded magnitude division: (|sum| + count/2) / count, sign restored after.
  assign mag_h   = sum_h_r[SHW-1] ? (~sum_h_r) + 1'b1 : sum_h_r;
  assign mag_e   = sum_e_r[SEW-1] ? (~sum_e_r) + 1'b1 : sum_e_r;
  assign div_num = ((cmd.div_sel == thar_pkg::DIV_SEL_ELEV) ? SHW'(mag_e) : mag_h)
                   + SHW'(cnt_r >> 1);

  thar_div #(
    .NUM_W(SHW),
    .DEN_W(CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cnt_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign quo_h = sum_h_r[SHW-1] ? (~div_quo) + 1'b1 : div_quo;
  assign quo_e = sum_e_r[SEW-1] ? (~div_quo) + 1'b1 : div_quo;

  // Held averages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_h_r <= '0;
      held_e_r <= '0;
    end else begin
      if (cmd.held_h_ld) begin
        held_h_r <= quo_h[HW-1:0];
      end
      if (cmd.held_e_ld) begin
        held_e_r <= quo_e[EWD-1:0];
      end
    end
  end

  // Heading error wrap: greedy add or subtract of 23040 << j, one j per cycle.
  assign e_init  = ERW'(held_h_r) - ERW'(gyro_r);
  assign stepv   = thar_pkg::FULL_TURN <<< wj_r;
  assign cand_dn = e_r - stepv;
  assign cand_up = e_r + stepv;

  always_ff @(posedge clk) begin
    if (cmd.wrap_init) begin
      e_r    <= e_init;
      wneg_r <= e_init[ERW-1];
      wj_r   <= SW'(thar_pkg::WRAP_STEPS - 1);
    end else if (cmd.wrap_step) begin
      if (!wneg_r) begin
        if (cand_dn > thar_pkg::NEG_HALF_TURN) begin
          e_r <= cand_dn;
        end
      end else begin
        if (cand_up < thar_pkg::HALF_TURN) begin
          e_r <= cand_up;
        end
      end
      wj_r <= wj_r - SW'(1);
    end
  end

  // Wrapped error magnitude and the gain product.
  assign abs_e = e_r[ERW-1] ? (~e_r) + 1'b1 : e_r;
  assign ae    = abs_e[MGW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= PW'(cfg.gain) * PW'(ae);
    end
  end

  // Rounded, offset by the minimum drive, clipped to the maximum drive.
  assign rnd      = (prod_r + PW'(thar_pkg::ROUND_BIAS)) >> thar_pkg::ROT_SHIFT;
  assign mag_sum  = MSW'(rnd[RNW-1:0]) + MSW'(cfg.min_drive);
  assign mag      = (mag_sum > MSW'(cfg.max_drive)) ? cfg.max_drive : mag_sum[DRW-1:0];
  assign mag_ext  = RTW'(mag);
  assign rot_val  = e_r[ERW-1] ? RTW'(0) - mag_ext : mag_ext;
  assign active   = lock_r && gyro_ok_r;
  assign band_hit = (ae <= cfg.deadband);

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_locked         <= lock_r;
      out_mean_heading   <= held_h_r;
      out_mean_elevation <= held_e_r;
      out_rotation       <= (active && !band_hit) ? rot_val : '0;
      out_aligned        <= active && band_hit;
    end
  end

  // Status to the controller.
  assign sts.sweep_last = (rd_ptr_r == AW'(HISTORY_DEPTH - 1));
  assign sts.lock_ok    = (MW'(cnt_r) >= MW'(need));
  assign sts.div_busy   = div_busy;
  assign sts.wrap_last  = (wj_r == '0);

endmodule

// ----- src/target_heading_average_and_rotate.sv -----
// Top level of the target heading averager and rotate block.
// Depends on thar_pkg, thar_regs, thar_ctrl and thar_dp.
`timescale 1ns / 1ps

// One input transaction is one control tick and produces exactly one result. The
// block works on one tick at a time and takes no new tick until the result of the
// last one is in the output register. The time per tick is set by the sweep that
// reads every ring entry through the single RAM read port and, when the tick locks,
// by the bit-serial divider that forms the heading average and then the elevation
// average, one quotient bit per cycle. A finished result waits in the output
// register, so the next tick is accepted while it is still stalled. Configuration
// goes through the APB-style port; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module target_heading_average_and_rotate #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [thar_pkg::ADDR_W-1:0]         paddr,
  input  logic [thar_pkg::DATA_W-1:0]         pwdata,
  output logic [thar_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [thar_pkg::BEAR_W-1:0]  in_bearing,
  input  logic signed [thar_pkg::ELEV_W-1:0]  in_elevation,
  input  logic                                in_seen,
  input  logic signed [thar_pkg::HEAD_W-1:0]  in_gyro_heading,
  input  logic                                in_gyro_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_locked,
  output logic signed [thar_pkg::HEAD_W-1:0]  out_mean_heading,
  output logic signed [thar_pkg::ELEV_W-1:0]  out_mean_elevation,
  output logic signed [thar_pkg::ROT_W-1:0]   out_rotation,
  output logic                                out_aligned
);

  thar_pkg::cfg_t cfg;
  thar_pkg::cmd_t cmd;
  thar_pkg::sts_t sts;

  // Configuration registers.
  thar_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  thar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  thar_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg                (cfg),
    .in_bearing         (in_bearing),
    .in_elevation       (in_elevation),
    .in_seen            (in_seen),
    .in_gyro_heading    (in_gyro_heading),
    .in_gyro_ok         (in_gyro_ok),
    .out_locked         (out_locked),
    .out_mean_heading   (out_mean_heading),
    .out_mean_elevation (out_mean_elevation),
    .out_rotation       (out_rotation),
    .out_aligned        (out_aligned)
  );

endmodule

// ----- src/thar_chk.sv -----
// Port-level checker for the target heading averager and rotate block, with its bind.
// Depends on thar_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "target_heading_average_and_rotate_macros.svh"

module thar_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_locked,
  input logic signed [thar_pkg::ROT_W-1:0]  out_rotation,
  input logic                               out_aligned
);

  // Alignment is only reported with a lock.
  `THAR_ASSERT_IMP(a_aligned_needs_lock, out_valid && out_aligned, out_locked, "aligned without lock")

  // An aligned result drives no rotation.
  `THAR_ASSERT_IMP(a_aligned_no_rot, out_valid && out_aligned, out_rotation == '0, "rotation while aligned")

  // Without a lock the rotation is zero.
  `THAR_ASSERT_IMP(a_unlocked_no_rot, out_valid && !out_locked, out_rotation == '0, "rotation without lock")

  // A tick is processed alone: the input stalls right after an acceptance.
  `THAR_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second tick taken while busy")

  // A stalled result stays presented.
  `THAR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rotation), "result dropped")

endmodule

bind target_heading_average_and_rotate thar_chk u_chk (.*);
